// ===== rtl/ppr_pkg.sv =====
// Shared constants and types for the progress percentile rank block.
// Used by the user store, histogram store, divider and the top level.
// Depends on nothing else.
package ppr_pkg;

    // Field widths of the input and result beats.
    localparam int USER_W        = 10;
    localparam int PAGE_W        = 10;
    localparam int COUNT_W       = 11;
    localparam int FRACTION_BITS = 24;
    localparam int FRAC_W        = FRACTION_BITS + 1;

    // Store sizes.
    localparam int MAX_USERS = 1024;
    localparam int MAX_PAGES = 1024;
    localparam int USER_AW   = $clog2(MAX_USERS);
    localparam int PAGE_AW   = $clog2(MAX_PAGES);

    // The clearing sweep covers the deeper of the two stores.
    localparam int CLEAR_DEPTH = (MAX_USERS > MAX_PAGES) ? MAX_USERS : MAX_PAGES;
    localparam int CLEAR_AW    = $clog2(CLEAR_DEPTH);

    // Serial divider: the dividend is the behind count shifted up by the fraction bits.
    localparam int DIV_W     = COUNT_W + FRACTION_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // Action codes.
    localparam logic ACT_SET   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [PAGE_AW-1:0] page;
    } user_entry_t;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [USER_AW-1:0] addr;
        user_entry_t        wdata;
    } user_req_t;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [PAGE_AW-1:0] addr;
        logic [COUNT_W-1:0] wdata;
    } hist_req_t;

endpackage

// ===== rtl/progress_percentile_rank_core.sv =====
// Progress percentile rank: per-user page records and a page histogram.
// Instantiates ppr_user_store, ppr_hist_store and ppr_divider; uses ppr_pkg.
//
// Usage. The input channel (s_valid/s_ready) carries one beat per item:
// s_action 0 records s_page_count as the page of s_user_id, s_action 1
// queries the rank of s_user_id. Updates give no result beat. A query gives
// one beat on the result channel (m_valid/m_ready): the share of other known
// users at a strictly lower page as a Q1.24 fraction, the behind count, the
// number of known users and whether the queried user is known.
// Timing. One item is worked on at a time. An update reads the user record,
// then, for a user already known, decrements the old page's bin, then reads
// and increments the new page's bin. A query of a known user at page P, with
// more than one user known, reads the histogram bins below P one by one
// through the single port and then runs the bit-serial divider. Queries of
// unknown or lone users skip both.
// Reset. After aresetn is released, a clearing sweep zeroes the user valid
// flags and the histogram; s_ready stays low meanwhile.
// Stalls. The result sits in an output register; the next item is accepted
// while it waits. A further query holds in its last state until the
// receiver has taken the earlier result beat.
module progress_percentile_rank_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [ppr_pkg::USER_W-1:0]         s_user_id,
    input  logic [ppr_pkg::PAGE_W-1:0]         s_page_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ppr_pkg::FRAC_W-1:0]         m_rank_fraction,
    output logic [ppr_pkg::COUNT_W-1:0]        m_behind_count,
    output logic [ppr_pkg::COUNT_W-1:0]        m_known_users,
    output logic                               m_user_known
);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_LOOKUP = 9'b000000100,
        ST_DEC    = 9'b000001000,
        ST_INC_RD = 9'b000010000,
        ST_INC    = 9'b000100000,
        ST_SUM    = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_RESULT = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ppr_pkg::CLEAR_AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [ppr_pkg::COUNT_W-1:0]     total_reg, total_next;
    logic                            pend_reg, pend_next;
    logic                            m_valid_reg, m_valid_next;

    logic                            action_reg, action_next;
    logic [ppr_pkg::USER_W-1:0]      uid_reg, uid_next;
    logic [ppr_pkg::PAGE_AW-1:0]     page_reg, page_next;
    logic [ppr_pkg::PAGE_AW-1:0]     old_page_reg, old_page_next;
    logic                            known_reg, known_next;
    logic [ppr_pkg::PAGE_AW-1:0]     sum_addr_reg, sum_addr_next;
    logic [ppr_pkg::COUNT_W-1:0]     behind_reg, behind_next;
    logic [ppr_pkg::FRAC_W-1:0]      frac_reg, frac_next;

    logic [ppr_pkg::FRAC_W-1:0]      m_rank_fraction_reg;
    logic [ppr_pkg::COUNT_W-1:0]     m_behind_count_reg;
    logic [ppr_pkg::COUNT_W-1:0]     m_known_users_reg;
    logic                            m_user_known_reg;

    ppr_pkg::user_req_t              user_req;
    ppr_pkg::user_entry_t            user_rdata;
    ppr_pkg::hist_req_t              hist_req;
    logic [ppr_pkg::COUNT_W-1:0]     hist_rdata;

    logic                            div_start;
    logic                            div_done;
    logic [ppr_pkg::DIV_W-1:0]       div_quot;

    logic [ppr_pkg::PAGE_AW-1:0]     page_in;
    logic                            uid_ok;
    logic                            user_hit;
    logic                            sum_issue;
    logic                            out_load;

    ppr_user_store u_user_store (
        .aclk  (aclk),
        .req   (user_req),
        .rdata (user_rdata)
    );

    ppr_hist_store u_hist_store (
        .aclk  (aclk),
        .req   (hist_req),
        .rdata (hist_rdata)
    );

    ppr_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({behind_reg, {ppr_pkg::FRACTION_BITS{1'b0}}}),
        .divisor  (total_reg - ppr_pkg::COUNT_W'(1)),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Pages beyond the histogram saturate to its last bin.
    assign page_in = (32'(s_page_count) >= ppr_pkg::MAX_PAGES) ?
                     ppr_pkg::PAGE_AW'(ppr_pkg::MAX_PAGES - 1) :
                     s_page_count[ppr_pkg::PAGE_AW-1:0];
    assign uid_ok    = (32'(uid_reg) < ppr_pkg::MAX_USERS);
    assign user_hit  = uid_ok && user_rdata.valid;
    assign sum_issue = (sum_addr_reg < page_reg);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        total_next    = total_reg;
        pend_next     = 1'b0;
        action_next   = action_reg;
        uid_next      = uid_reg;
        page_next     = page_reg;
        old_page_next = old_page_reg;
        known_next    = known_reg;
        sum_addr_next = sum_addr_reg;
        behind_next   = behind_reg;
        frac_next     = frac_reg;
        user_req      = '0;
        hist_req      = '0;
        div_start     = 1'b0;
        s_ready       = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                user_req.wr  = ({1'b0, clr_cnt_reg} <
                                (ppr_pkg::CLEAR_AW + 1)'(ppr_pkg::MAX_USERS));
                user_req.addr = clr_cnt_reg[ppr_pkg::USER_AW-1:0];
                hist_req.wr  = ({1'b0, clr_cnt_reg} <
                                (ppr_pkg::CLEAR_AW + 1)'(ppr_pkg::MAX_PAGES));
                hist_req.addr = clr_cnt_reg[ppr_pkg::PAGE_AW-1:0];
                clr_cnt_next = clr_cnt_reg + ppr_pkg::CLEAR_AW'(1);
                if (clr_cnt_reg == ppr_pkg::CLEAR_AW'(ppr_pkg::CLEAR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next   = s_action;
                    uid_next      = s_user_id;
                    page_next     = page_in;
                    user_req.rd   = 1'b1;
                    user_req.addr = s_user_id[ppr_pkg::USER_AW-1:0];
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                known_next    = user_hit;
                old_page_next = user_rdata.page;
                if (action_reg == ppr_pkg::ACT_SET) begin
                    if (!uid_ok) begin
                        state_next = ST_IDLE;
                    end else begin
                        user_req.wr         = 1'b1;
                        user_req.addr       = uid_reg[ppr_pkg::USER_AW-1:0];
                        user_req.wdata.valid = 1'b1;
                        user_req.wdata.page  = page_reg;
                        if (user_hit) begin
                            hist_req.rd   = 1'b1;
                            hist_req.addr = user_rdata.page;
                            state_next    = ST_DEC;
                        end else begin
                            total_next = total_reg + ppr_pkg::COUNT_W'(1);
                            state_next = ST_INC_RD;
                        end
                    end
                end else begin
                    behind_next   = '0;
                    sum_addr_next = '0;
                    page_next     = user_rdata.page;
                    if (!user_hit) begin
                        frac_next  = '0;
                        state_next = ST_RESULT;
                    end else if (total_reg <= ppr_pkg::COUNT_W'(1)) begin
                        frac_next  = ppr_pkg::FRAC_ONE;
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_DEC: begin
                hist_req.wr    = 1'b1;
                hist_req.addr  = old_page_reg;
                hist_req.wdata = (hist_rdata != '0) ?
                                 (hist_rdata - ppr_pkg::COUNT_W'(1)) : hist_rdata;
                state_next     = ST_INC_RD;
            end
            ST_INC_RD: begin
                // Issued in the state after the decrement so that a page left
                // unchanged reads back its decremented bin.
                hist_req.rd   = 1'b1;
                hist_req.addr = page_reg;
                state_next    = ST_INC;
            end
            ST_INC: begin
                hist_req.wr    = 1'b1;
                hist_req.addr  = page_reg;
                hist_req.wdata = hist_rdata + ppr_pkg::COUNT_W'(1);
                state_next     = ST_IDLE;
            end
            ST_SUM: begin
                // Reads run one bin per cycle; each bin is added when its data returns.
                if (sum_issue) begin
                    hist_req.rd   = 1'b1;
                    hist_req.addr = sum_addr_reg;
                    sum_addr_next = sum_addr_reg + ppr_pkg::PAGE_AW'(1);
                    pend_next     = 1'b1;
                end
                if (pend_reg) begin
                    behind_next = behind_reg + hist_rdata;
                end
                if (!sum_issue && !pend_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    frac_next  = div_quot[ppr_pkg::FRAC_W-1:0];
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        uid_reg      <= uid_next;
        page_reg     <= page_next;
        old_page_reg <= old_page_next;
        known_reg    <= known_next;
        sum_addr_reg <= sum_addr_next;
        behind_reg   <= behind_next;
        frac_reg     <= frac_next;
        if (out_load) begin
            m_rank_fraction_reg <= frac_reg;
            m_behind_count_reg  <= behind_reg;
            m_known_users_reg   <= total_reg;
            m_user_known_reg    <= known_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rank_fraction = m_rank_fraction_reg;
    assign m_behind_count  = m_behind_count_reg;
    assign m_known_users   = m_known_users_reg;
    assign m_user_known    = m_user_known_reg;

`ifndef SYNTHESIS
    // A known user always occupies its old bin, so a decrement never meets zero.
    a_dec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEC) |-> (hist_rdata != '0))
        else $error("histogram bin of a known user read as zero");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= ppr_pkg::COUNT_W'(ppr_pkg::MAX_USERS))
        else $error("known user count beyond the user store");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the division state");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOOKUP && !s_ready))
        else $error("accepted beat did not start a lookup");
`endif

endmodule

// ===== rtl/ppr_user_store.sv =====
// Per-user record memory: a valid flag and the last page of each user.
// Single port, registered read. Depends on ppr_pkg.
module ppr_user_store (
    input  logic                  aclk,
    input  ppr_pkg::user_req_t    req,
    output ppr_pkg::user_entry_t  rdata
);

    ppr_pkg::user_entry_t mem [ppr_pkg::MAX_USERS];
    ppr_pkg::user_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ppr_hist_store.sv =====
// Page histogram memory: number of users currently at each page.
// Single port, registered read. Depends on ppr_pkg.
module ppr_hist_store (
    input  logic                          aclk,
    input  ppr_pkg::hist_req_t            req,
    output logic [ppr_pkg::COUNT_W-1:0]   rdata
);

    logic [ppr_pkg::COUNT_W-1:0] mem [ppr_pkg::MAX_PAGES];
    logic [ppr_pkg::COUNT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ppr_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the rank fraction.
// Depends on ppr_pkg for the operand widths.
module ppr_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ppr_pkg::DIV_W-1:0]    dividend,
    input  logic [ppr_pkg::COUNT_W-1:0]  divisor,
    output logic                         done,
    output logic [ppr_pkg::DIV_W-1:0]    quotient
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [ppr_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [ppr_pkg::DIV_W-1:0]      shift_reg;
    logic [ppr_pkg::COUNT_W-1:0]    rem_reg;
    logic [ppr_pkg::COUNT_W-1:0]    dsr_reg;

    logic [ppr_pkg::COUNT_W:0]      trial;
    logic [ppr_pkg::COUNT_W:0]      diff;
    logic                           fits;

    // The remainder always stays below the divisor, so it fits the divisor width.
    assign trial = {rem_reg, shift_reg[ppr_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ppr_pkg::DIV_CNT_W'(ppr_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - ppr_pkg::DIV_CNT_W'(1);
                if (cnt_reg == ppr_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dsr_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[ppr_pkg::DIV_W-2:0], fits};
            rem_reg   <= fits ? diff[ppr_pkg::COUNT_W-1:0] : trial[ppr_pkg::COUNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ===== sim/progress_percentile_rank_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for progress_percentile_rank_core: random bursts of page records
// and rank queries, checked beat by beat against an in-bench model of the histogram.
// Depends on rtl/ppr_pkg.sv and the RTL of the block.
module progress_percentile_rank_core_test;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          RANDOM_ITEMS = 520;
    localparam int          TAIL_CYCLES  = 64;

    typedef struct {
        logic                        action;
        logic [ppr_pkg::USER_W-1:0]  user_id;
        logic [ppr_pkg::PAGE_W-1:0]  page;
    } progress_item_t;

    typedef struct {
        logic [ppr_pkg::FRAC_W-1:0]  fraction;
        logic [ppr_pkg::COUNT_W-1:0] behind;
        logic [ppr_pkg::COUNT_W-1:0] known_users;
        logic                        user_known;
    } rank_answer_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_action = ppr_pkg::ACT_SET;
    logic [ppr_pkg::USER_W-1:0]   s_user_id = '0;
    logic [ppr_pkg::PAGE_W-1:0]   s_page_count = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [ppr_pkg::FRAC_W-1:0]   m_rank_fraction;
    logic [ppr_pkg::COUNT_W-1:0]  m_behind_count;
    logic [ppr_pkg::COUNT_W-1:0]  m_known_users;
    logic                         m_user_known;

    progress_item_t pending_items[$];
    rank_answer_t   rank_answers_due[$];

    // Shadow of the block's stores, updated as each beat is accepted.
    logic [ppr_pkg::PAGE_W-1:0]  page_of_user[ppr_pkg::MAX_USERS];
    bit                          user_recorded[ppr_pkg::MAX_USERS];
    logic [ppr_pkg::COUNT_W-1:0] users_at_page[ppr_pkg::MAX_PAGES];
    logic [ppr_pkg::COUNT_W-1:0] recorded_users;

    int unsigned cycle_count;
    int          error_count;
    int          updates_taken;
    int          queries_taken;
    int          unknown_queries;
    int          lone_queries;
    int          answers_checked;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_left;

    // Generator-side record of which users have been given a page.
    bit          gen_known[ppr_pkg::MAX_USERS];
    int          gen_known_ids[$];

    progress_percentile_rank_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_user_id       (s_user_id),
        .s_page_count    (s_page_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rank_fraction (m_rank_fraction),
        .m_behind_count  (m_behind_count),
        .m_known_users   (m_known_users),
        .m_user_known    (m_user_known)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic add_item(input logic action, input int user_id, input int page);
        progress_item_t item;
        item.action  = action;
        item.user_id = user_id[ppr_pkg::USER_W-1:0];
        item.page    = page[ppr_pkg::PAGE_W-1:0];
        pending_items.push_back(item);
        if (action == ppr_pkg::ACT_SET && !gen_known[user_id]) begin
            gen_known[user_id] = 1'b1;
            gen_known_ids.push_back(user_id);
        end
    endtask

    // Records a page or works out the rank answer for one accepted beat.
    task automatic apply_progress_item(input logic action,
                                       input logic [ppr_pkg::USER_W-1:0] user_id,
                                       input logic [ppr_pkg::PAGE_W-1:0] page);
        rank_answer_t answer;
        longint unsigned behind_sum;
        if (action == ppr_pkg::ACT_SET) begin
            updates_taken++;
            if (user_recorded[user_id]) begin
                if (users_at_page[page_of_user[user_id]] != 0)
                    users_at_page[page_of_user[user_id]]--;
            end else begin
                user_recorded[user_id] = 1'b1;
                recorded_users++;
            end
            page_of_user[user_id] = page;
            users_at_page[page]++;
        end else begin
            queries_taken++;
            answer.fraction    = '0;
            answer.behind      = '0;
            answer.known_users = recorded_users;
            answer.user_known  = user_recorded[user_id];
            if (!user_recorded[user_id]) begin
                unknown_queries++;
            end else if (recorded_users <= 1) begin
                lone_queries++;
                answer.fraction = ppr_pkg::FRAC_ONE;
            end else begin
                behind_sum = 0;
                for (int p = 0; p < page_of_user[user_id]; p++)
                    behind_sum += users_at_page[p];
                answer.behind   = behind_sum[ppr_pkg::COUNT_W-1:0];
                answer.fraction = ppr_pkg::FRAC_W'((behind_sum << ppr_pkg::FRACTION_BITS) /
                                                   (recorded_users - 1));
            end
            rank_answers_due.push_back(answer);
        end
    endtask

    // Driver: presents queued items in bursts separated by random gaps.
    always @(posedge aclk) begin : drive_items
        progress_item_t queued;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_action     <= ppr_pkg::ACT_SET;
            s_user_id    <= '0;
            s_page_count <= '0;
        end else begin
            if (s_valid && s_ready)
                apply_progress_item(s_action, s_user_id, s_page_count);
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    queued = pending_items.pop_front();
                    s_valid      <= 1'b1;
                    s_action     <= queued.action;
                    s_user_id    <= queued.user_id;
                    s_page_count <= queued.page;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: alternates stretches of steady ready, random ready and long stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(1, 40);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= 1'b0;
            endcase
        end
    end

    // Monitor: every result beat is matched against the oldest answer due.
    always @(posedge aclk) begin : check_answers
        rank_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rank_answers_due.size() == 0) begin
                $error("result beat with no query outstanding");
                error_count++;
            end else begin
                want = rank_answers_due.pop_front();
                answers_checked++;
                if (m_rank_fraction !== want.fraction) begin
                    $error("rank_fraction: expected %0d, got %0d", want.fraction,
                           m_rank_fraction);
                    error_count++;
                end
                if (m_behind_count !== want.behind) begin
                    $error("behind_count: expected %0d, got %0d", want.behind,
                           m_behind_count);
                    error_count++;
                end
                if (m_known_users !== want.known_users) begin
                    $error("known_users: expected %0d, got %0d", want.known_users,
                           m_known_users);
                    error_count++;
                end
                if (m_user_known !== want.user_known) begin
                    $error("user_known: expected %0d, got %0d", want.user_known,
                           m_user_known);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("progress_percentile_rank_core: mismatch");
            $finish;
        end
    end

    initial begin
        int pick;
        int user_id;
        int page;
        recorded_users = '0;
        for (int i = 0; i < ppr_pkg::MAX_PAGES; i++)
            users_at_page[i] = '0;
        for (int i = 0; i < ppr_pkg::MAX_USERS; i++) begin
            page_of_user[i]  = '0;
            user_recorded[i] = 1'b0;
            gen_known[i]     = 1'b0;
        end

        // Directed part: empty store, lone user, ties, re-recorded users, extreme ids and pages.
        add_item(ppr_pkg::ACT_QUERY, 0, 1023);
        add_item(ppr_pkg::ACT_SET, 5, 1023);
        add_item(ppr_pkg::ACT_QUERY, 5, 0);
        add_item(ppr_pkg::ACT_SET, 1023, 0);
        add_item(ppr_pkg::ACT_QUERY, 5, 0);
        add_item(ppr_pkg::ACT_QUERY, 1023, 1023);
        add_item(ppr_pkg::ACT_SET, 5, 0);
        add_item(ppr_pkg::ACT_QUERY, 5, 0);
        add_item(ppr_pkg::ACT_SET, 0, 512);
        add_item(ppr_pkg::ACT_SET, 682, 341);
        add_item(ppr_pkg::ACT_SET, 341, 682);
        add_item(ppr_pkg::ACT_QUERY, 0, 0);
        add_item(ppr_pkg::ACT_QUERY, 682, 0);
        add_item(ppr_pkg::ACT_QUERY, 341, 0);
        add_item(ppr_pkg::ACT_SET, 1023, 1023);
        add_item(ppr_pkg::ACT_QUERY, 1023, 0);
        add_item(ppr_pkg::ACT_QUERY, 512, 682);
        add_item(ppr_pkg::ACT_SET, 341, 341);
        add_item(ppr_pkg::ACT_QUERY, 0, 0);
        add_item(ppr_pkg::ACT_QUERY, 5, 1023);

        // Random part: mostly records and queries of users already seen, some strangers.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if ($urandom_range(0, 9) < 6 && gen_known_ids.size() > 0)
                    user_id = gen_known_ids[$urandom_range(0, gen_known_ids.size() - 1)];
                else
                    user_id = $urandom_range(0, ppr_pkg::MAX_USERS - 1);
                case ($urandom_range(0, 5))
                    0: page = $urandom_range(0, 15);
                    1: page = ($urandom_range(0, 1) == 0) ? 0 : ppr_pkg::MAX_PAGES - 1;
                    default: page = $urandom_range(0, ppr_pkg::MAX_PAGES - 1);
                endcase
                add_item(ppr_pkg::ACT_SET, user_id, page);
            end else begin
                if ($urandom_range(0, 99) < 85 && gen_known_ids.size() > 0)
                    user_id = gen_known_ids[$urandom_range(0, gen_known_ids.size() - 1)];
                else
                    user_id = $urandom_range(0, ppr_pkg::MAX_USERS - 1);
                add_item(ppr_pkg::ACT_QUERY, user_id,
                         $urandom_range(0, ppr_pkg::MAX_PAGES - 1));
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid)
            @(posedge aclk);
        while (rank_answers_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d page records and %0d rank queries (%0d strangers, %0d lone).",
                 updates_taken, queries_taken, unknown_queries, lone_queries);
        $display("%0d result beats compared, %0d users on record at the end.",
                 answers_checked, recorded_users);
        if (error_count == 0)
            $display("progress_percentile_rank_core: match");
        else
            $display("progress_percentile_rank_core: mismatch");
        $finish;
    end

endmodule

// ===== progress_percentile_rank_core.f =====
rtl/ppr_pkg.sv
rtl/ppr_user_store.sv
rtl/ppr_hist_store.sv
rtl/ppr_divider.sv
rtl/progress_percentile_rank_core.sv
sim/progress_percentile_rank_core_test.sv
